// ----- hw/rtl/sbus_frame_receiver_unit_defines.svh -----
// Assertion macros for the SBUS frame receiver RTL
`ifndef SBUS_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define SBUS_FRAME_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/sfr_pkg.sv -----
// Package: constants and types of the SBUS frame receiver
package sfr_pkg;

    localparam int FRAME_BYTES   = 25;
    localparam int IDX_W         = 5;
    localparam int CH_W          = 11;
    localparam int NUM_CH        = 16;
    localparam int CHAN_BITS     = NUM_CH * CH_W;
    localparam int CHAN_BYTES    = CHAN_BITS / 8;
    localparam int LEVEL_W       = 9;
    localparam int SEL_W         = 4;
    localparam int BITPOS_W      = 8;
    localparam int CFG_IDX_W     = 2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

    localparam logic [CFG_IDX_W-1:0] REG_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE   = 2'd2;

    localparam logic [7:0] HEADER_RST = 8'h0F;
    localparam logic [7:0] GAP_RST    = 8'd15;
    localparam logic [7:0] IDLE_RST   = 8'd156;

    localparam logic [CH_W-1:0] CH_MAX = 11'h7FF;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic            status;
        logic [CH_W-1:0] ch0;
        logic [CH_W-1:0] sel_val;
        logic [7:0]      header;
    } sfr_frame_t;

    typedef struct packed {
        logic       valid;
        sfr_frame_t frame;
    } sfr_push_t;

    typedef struct packed {
        logic       valid;
        logic       full;
        sfr_frame_t frame;
    } sfr_qstat_t;

endpackage

// ----- hw/rtl/sfr_in_if.sv -----
// Interface: input item channel
interface sfr_in_if
    import sfr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [7:0]       rx_byte;
    logic [SEL_W-1:0] channel_select;

    modport source (output valid, kind, rx_byte, channel_select, input ready);
    modport sink   (input valid, kind, rx_byte, channel_select, output ready);
endinterface

// ----- hw/rtl/sfr_out_if.sv -----
// Interface: decoded frame result channel
interface sfr_out_if
    import sfr_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               status;
    logic [CH_W-1:0]    channel_zero;
    logic [CH_W-1:0]    selected_value;
    logic [LEVEL_W-1:0] level;
    logic [7:0]         header_byte;

    modport source (output valid, status, channel_zero, selected_value, level, header_byte,
                    input ready);
    modport sink   (input valid, status, channel_zero, selected_value, level, header_byte,
                    output ready);
endinterface

// ----- hw/rtl/sfr_cfg_if.sv -----
// Interface: configuration register write channel
interface sfr_cfg_if
    import sfr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/sfr_front.sv -----
// Front end: byte/tick intake, frame assembly, header check, channel extraction
module sfr_front
    import sfr_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    sfr_in_if.sink          rx_in,
    sfr_cfg_if.sink         cfg,
    input  logic            q_full,
    output sfr_push_t       push
);

    logic [7:0]       header_value_reg;
    logic [7:0]       gap_limit_reg;
    logic [7:0]       idle_limit_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       sil_reg, sil_next;
    logic [7:0]       frame_reg [FRAME_BYTES];

    logic                 take;
    logic                 complete;
    logic [CHAN_BITS-1:0] chan_bits;
    logic [BITPOS_W-1:0]  bitpos;
    logic [CH_W-1:0]      ch0;
    logic [CH_W-1:0]      sel_val;
    logic                 hdr_ok;

    assign rx_in.ready = !q_full;
    assign cfg.ready   = 1'b1;
    assign take        = rx_in.valid && rx_in.ready;
    assign complete    = take && (rx_in.kind == KIND_BYTE) && (idx_reg == LAST_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_value_reg <= HEADER_RST;
            gap_limit_reg    <= GAP_RST;
            idle_limit_reg   <= IDLE_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_HEADER: header_value_reg <= cfg.data;
                REG_GAP:    gap_limit_reg    <= cfg.data;
                REG_IDLE:   idle_limit_reg   <= cfg.data;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        sil_next = sil_reg;
        if (take)
        begin
            if (rx_in.kind == KIND_TICK)
            begin
                if (sil_reg > gap_limit_reg)
                    idx_next = '0;
                if (sil_reg < idle_limit_reg)
                    sil_next = sil_reg + 8'd1;
                else
                    idx_next = '0;
            end
            else
            begin
                sil_next = '0;
                if (idx_reg >= LAST_IDX)
                    idx_next = '0;
                else
                    idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            sil_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            sil_reg <= sil_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && (rx_in.kind == KIND_BYTE) && (idx_reg <= LAST_IDX))
            frame_reg[idx_reg] <= rx_in.rx_byte;
    end

    // channel payload starts at byte 1, little-endian bit order
    always_comb
    begin
        for (int i = 0; i < CHAN_BYTES; i++)
            chan_bits[i*8 +: 8] = frame_reg[i+1];
    end

    assign bitpos  = BITPOS_W'(rx_in.channel_select) * BITPOS_W'(CH_W);
    assign ch0     = chan_bits[CH_W-1:0];
    assign sel_val = chan_bits[bitpos +: CH_W];
    assign hdr_ok  = (frame_reg[0] == header_value_reg);

    always_comb
    begin
        push.valid = complete;
        if (hdr_ok)
        begin
            push.frame.status  = STATUS_OK;
            push.frame.ch0     = ch0;
            push.frame.sel_val = sel_val;
            push.frame.header  = '0;
        end
        else
        begin
            push.frame.status  = STATUS_BAD;
            push.frame.ch0     = '0;
            push.frame.sel_val = '0;
            push.frame.header  = frame_reg[0];
        end
    end

endmodule

// ----- hw/rtl/sfr_queue.sv -----
// Two-entry queue of completed frames between front and back
module sfr_queue
    import sfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sfr_push_t  push,
    input  logic       pop,
    output sfr_qstat_t qstat
);

    sfr_frame_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_push;
    logic       do_pop;

    assign do_push = push.valid && (count_reg != 2'd2);
    assign do_pop  = pop && (count_reg != 2'd0);

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (!do_push && do_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.frame;
    end

    assign qstat.valid = (count_reg != 2'd0);
    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.frame = mem_reg[rd_ptr_reg];

endmodule

// ----- hw/rtl/sfr_back.sv -----
// Back end: min/max tracking, iterative level division, result register
`include "sbus_frame_receiver_unit_defines.svh"

module sfr_back
    import sfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sfr_qstat_t qstat,
    output logic       pop,
    sfr_out_if.source  res_out
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [3:0] LAST_STEP = 4'd8;

    logic [1:0]         state_reg, state_next;
    logic [CH_W-1:0]    lo_reg, lo_next;
    logic [CH_W-1:0]    hi_reg, hi_next;
    logic               status_reg, status_next;
    logic [CH_W-1:0]    ch0_reg, ch0_next;
    logic [CH_W-1:0]    val_reg, val_next;
    logic [7:0]         hdr_reg, hdr_next;
    logic [CH_W:0]      rem_reg, rem_next;
    logic [CH_W-1:0]    den_reg, den_next;
    logic [LEVEL_W-1:0] quo_reg, quo_next;
    logic [3:0]         step_reg, step_next;
    logic [CH_W:0]      trial;

    assign trial = (step_reg == '0) ? rem_reg : {rem_reg[CH_W-1:0], 1'b0};

    always_comb
    begin
        state_next  = state_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        status_next = status_reg;
        ch0_next    = ch0_reg;
        val_next    = val_reg;
        hdr_next    = hdr_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        quo_next    = quo_reg;
        step_next   = step_reg;
        pop         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (qstat.valid)
                begin
                    pop         = 1'b1;
                    status_next = qstat.frame.status;
                    ch0_next    = qstat.frame.ch0;
                    val_next    = qstat.frame.sel_val;
                    hdr_next    = qstat.frame.header;
                    quo_next    = '0;
                    if (qstat.frame.status == STATUS_OK)
                    begin
                        if (qstat.frame.sel_val > hi_reg)
                            hi_next = qstat.frame.sel_val;
                        if (qstat.frame.sel_val < lo_reg)
                            lo_next = qstat.frame.sel_val;
                        state_next = ST_PREP;
                    end
                    else
                        state_next = ST_OUT;
                end
            end
            ST_PREP:
            begin
                den_next  = hi_reg - lo_reg;
                rem_next  = {1'b0, val_reg - lo_reg};
                quo_next  = '0;
                step_next = '0;
                if (hi_reg > lo_reg)
                    state_next = ST_DIV;
                else
                    state_next = ST_OUT;
            end
            ST_DIV:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = trial - {1'b0, den_reg};
                    quo_next = {quo_reg[LEVEL_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[LEVEL_W-2:0], 1'b0};
                end
                step_next = step_reg + 4'd1;
                if (step_reg == LAST_STEP)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (res_out.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lo_reg    <= CH_MAX;
            hi_reg    <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        ch0_reg    <= ch0_next;
        val_reg    <= val_next;
        hdr_reg    <= hdr_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        quo_reg    <= quo_next;
    end

    assign res_out.valid          = (state_reg == ST_OUT);
    assign res_out.status         = status_reg;
    assign res_out.channel_zero   = ch0_reg;
    assign res_out.selected_value = val_reg;
    assign res_out.level          = quo_reg;
    assign res_out.header_byte    = hdr_reg;

    `SFR_ASSERT_NOW(a_level_range, res_out.valid, res_out.level <= 9'd256, "level above 256")
    `SFR_ASSERT_NOW(a_bad_zero, res_out.valid && res_out.status == STATUS_BAD, res_out.level == '0 && res_out.selected_value == '0, "mismatch result not cleared")
    `SFR_ASSERT_NEXT(a_div_end, state_reg == ST_DIV && step_reg == LAST_STEP, state_reg == ST_OUT, "division did not finish")
    `SFR_ASSERT_NOW(a_rem_bound, state_reg == ST_DIV && step_reg != '0, rem_reg < {1'b0, den_reg}, "remainder not reduced")

endmodule

// ----- hw/rtl/sbus_frame_receiver_unit.sv -----
// Top level: SBUS frame receiver, front end, frame queue and back end
//
// channel   role    transaction
// rx_in     sink    one received byte or one timer tick
// res_out   source  one decoded frame (or header mismatch report)
// cfg       sink    one register write: 0 header, 1 gap limit, 2 idle limit
//
// rx_in takes one item per cycle while the two-entry frame queue has room.
// A frame result is offered from the out state: directly from idle on a header
// mismatch, after prep on a flat range, and after prep and the 9-step restoring
// divider otherwise. The back end then returns to idle before its next pop.
// res_out stalls hold the result register; the queue then absorbs frames.
// rst_n resets indices, counters, min/max and the config registers to their defaults.
module sbus_frame_receiver_unit
    import sfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sfr_in_if.sink     rx_in,
    sfr_out_if.source  res_out,
    sfr_cfg_if.sink    cfg
);

    sfr_push_t  push;
    sfr_qstat_t qstat;
    logic       pop;

    sfr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx_in  (rx_in),
        .cfg    (cfg),
        .q_full (qstat.full),
        .push   (push)
    );

    sfr_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .qstat (qstat)
    );

    sfr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .qstat   (qstat),
        .pop     (pop),
        .res_out (res_out)
    );

endmodule
